FILE: rtl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, constants and the Bernstein weight table of the cubic Bezier
// stroke tessellator.
// ----------------------------------------------------------------------------
package bst_pkg;

  // Number of equal steps of t per cubic group
  localparam int SEGMENTS = 20;
  localparam int SEG_W    = $clog2(SEGMENTS + 1);

  // Weight denominator and its double, for round half up
  localparam longint SEG_DEN  = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
  localparam longint SEG_DEN2 = 2 * SEG_DEN;

  // Point packing: x in [31:16], y in [15:0], both signed Q12.4
  typedef logic [31:0] point_t;

  // One unit of work for the back end
  typedef struct packed {
    point_t [3:0] pts;        // anchor, two inner points, end point / raw list
    logic   [1:0] first_idx;  // first raw point to emit
    logic   [1:0] last_idx;   // last raw point to emit
    logic         curve;      // 1: tessellate pts as one cubic group
    logic         lead;       // curve only: emit pts[0] raw before the samples
    logic         strip_end;  // last vertex of this job closes the stroke
  } job_t;

  // Front to queue write request
  typedef struct packed {
    logic valid;
    job_t job;
  } qpush_t;

  // Queue to back head view
  typedef struct packed {
    logic nonempty;
    job_t head;
  } qhead_t;

  // Weights in Q0.16, held in 17 bits so that 1.0 is exact
  typedef logic [16:0]         wt_t;
  typedef wt_t [3:0]           wrow_t;
  typedef wrow_t [SEGMENTS:0]  wtab_t;

  // Build the weight table at elaboration
  function automatic wtab_t build_wtab();
    wtab_t  t;
    longint u;
    longint jl;
    longint num [4];
    t = '0;
    for (int j = 0; j <= SEGMENTS; j++) begin
      jl     = longint'(j);
      u      = longint'(SEGMENTS) - jl;
      num[0] = u * u * u;
      num[1] = 3 * jl * u * u;
      num[2] = 3 * jl * jl * u;
      num[3] = jl * jl * jl;
      for (int k = 0; k < 4; k++) begin
        t[j][k] = wt_t'((num[k] * 131072 + SEG_DEN) / SEG_DEN2);
      end
    end
    return t;
  endfunction

  localparam wtab_t W_TAB = build_wtab();

endpackage

FILE: rtl/bst_front.sv
// ----------------------------------------------------------------------------
// bst_front
// Accepts stroke points, tracks anchor and pending points, and turns them
// into jobs for the back end (raw vertex list or one cubic group).
// Also holds the smooth_enable register.
// ----------------------------------------------------------------------------
module bst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic              in_stroke_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_smooth_enable,
  input  logic              q_full,
  output bst_pkg::qpush_t   q_push
);

  logic              smooth_r, smooth_nxt;
  bst_pkg::point_t   anchor_r, anchor_nxt;
  bst_pkg::point_t   pend_r [2];
  bst_pkg::point_t   pend_nxt [2];
  logic [1:0]        pc_r, pc_nxt;
  logic              have_r, have_nxt;
  logic              fgd_r, fgd_nxt;
  logic              acc;
  bst_pkg::point_t   p;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign acc       = in_valid && !q_full;
  assign p         = {in_x, in_y};

  // Classify the request and build its job
  always_comb begin
    smooth_nxt  = smooth_r;
    anchor_nxt  = anchor_r;
    pend_nxt[0] = pend_r[0];
    pend_nxt[1] = pend_r[1];
    pc_nxt      = pc_r;
    have_nxt    = have_r;
    fgd_nxt     = fgd_r;

    q_push               = '0;
    q_push.job.pts[0]    = anchor_r;
    q_push.job.pts[1]    = pend_r[0];
    q_push.job.pts[2]    = pend_r[1];
    q_push.job.pts[3]    = p;
    q_push.job.first_idx = {1'b0, fgd_r};
    q_push.job.strip_end = in_stroke_end;

    if (acc) begin
      if (!have_r) begin
        // First point of a stroke becomes the anchor; a lone point is dropped
        if (in_stroke_end) begin
          have_nxt = 1'b0;
          pc_nxt   = 2'd0;
          fgd_nxt  = 1'b0;
        end else begin
          anchor_nxt = p;
          have_nxt   = 1'b1;
          pc_nxt     = 2'd0;
          fgd_nxt    = 1'b0;
        end
      end else if (!smooth_r) begin
        // Pass through: anchor once, then each point
        q_push.valid        = 1'b1;
        q_push.job.pts[1]   = p;
        q_push.job.last_idx = 2'd1;
        fgd_nxt             = 1'b1;
        if (in_stroke_end) begin
          have_nxt = 1'b0;
          pc_nxt   = 2'd0;
          fgd_nxt  = 1'b0;
        end
      end else if (pc_r < 2'd2) begin
        if (in_stroke_end) begin
          // Short tail: emit leftover points raw
          q_push.valid                  = 1'b1;
          q_push.job.pts[pc_r + 2'd1]   = p;
          q_push.job.last_idx           = pc_r + 2'd1;
          have_nxt                      = 1'b0;
          pc_nxt                        = 2'd0;
          fgd_nxt                       = 1'b0;
        end else begin
          pend_nxt[pc_r[0]] = p;
          pc_nxt            = pc_r + 2'd1;
        end
      end else begin
        // Full group: tessellate, end point becomes the next anchor
        q_push.valid        = 1'b1;
        q_push.job.curve    = 1'b1;
        q_push.job.lead     = !fgd_r;
        q_push.job.last_idx = 2'd3;
        if (in_stroke_end) begin
          have_nxt = 1'b0;
          pc_nxt   = 2'd0;
          fgd_nxt  = 1'b0;
        end else begin
          anchor_nxt = p;
          pc_nxt     = 2'd0;
          fgd_nxt    = 1'b1;
        end
      end
    end

    // Mode change drops the stroke in progress
    if (cfg_valid && cfg_ready) begin
      smooth_nxt = cfg_smooth_enable;
      if (cfg_smooth_enable != smooth_r) begin
        have_nxt = 1'b0;
        pc_nxt   = 2'd0;
        fgd_nxt  = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= 1'b1;
      anchor_r <= '0;
      pc_r     <= 2'd0;
      have_r   <= 1'b0;
      fgd_r    <= 1'b0;
    end else begin
      smooth_r <= smooth_nxt;
      anchor_r <= anchor_nxt;
      pc_r     <= pc_nxt;
      have_r   <= have_nxt;
      fgd_r    <= fgd_nxt;
    end
  end

  // Pending points hold data only
  always_ff @(posedge clk) begin
    pend_r[0] <= pend_nxt[0];
    pend_r[1] <= pend_nxt[1];
  end

endmodule

FILE: rtl/bst_queue.sv
// ----------------------------------------------------------------------------
// bst_queue
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
module bst_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  bst_pkg::qpush_t  q_push,
  output logic             q_full,
  input  logic             q_pop,
  output bst_pkg::qhead_t  q_head
);

  bst_pkg::job_t ent_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_full          = (cnt_r == 2'd2);
  assign q_head.nonempty = (cnt_r != 2'd0);
  assign q_head.head     = ent_r[rd_ptr_r];

  assign do_push = q_push.valid && !q_full;
  assign do_pop  = q_pop && q_head.nonempty;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store job
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= q_push.job;
    end
  end

endmodule

FILE: rtl/bst_back.sv
// ----------------------------------------------------------------------------
// bst_back
// Runs jobs: issues one vertex per cycle while the pipeline is not stalled,
// with a load state between jobs, into a four-stage pipeline (weight fetch,
// multiply, pair add, final add/round/saturate) that ends in the output register.
// ----------------------------------------------------------------------------
module bst_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bst_pkg::qhead_t   q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic              out_strip_last
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_RAW   = 4'b0010,
    B_LEAD  = 4'b0100,
    B_CURVE = 4'b1000
  } bstate_t;

  localparam logic [bst_pkg::SEG_W-1:0] J_ONE  = bst_pkg::SEG_W'(1);
  localparam logic [bst_pkg::SEG_W-1:0] J_LAST = bst_pkg::SEG_W'(bst_pkg::SEGMENTS);

  bstate_t                    st_r, st_nxt;
  bst_pkg::job_t              job_r, job_nxt;
  logic [1:0]                 idx_r, idx_nxt;
  logic [bst_pkg::SEG_W-1:0]  j_r, j_nxt;
  logic                       en;

  // Issue stage outputs
  logic                       iss_valid, iss_raw, iss_last;
  bst_pkg::point_t            iss_pt;

  // Stage I: weights and control points
  logic                       i_valid_r, i_raw_r, i_last_r;
  bst_pkg::point_t            i_pts_r [4];
  bst_pkg::wrow_t             i_w_r;

  // Stage M: products
  logic                       m_valid_r, m_raw_r, m_last_r;
  bst_pkg::point_t            m_pt_r;
  logic signed [33:0]         m_px_r [4];
  logic signed [33:0]         m_py_r [4];

  // Stage S: pair sums
  logic                       s_valid_r, s_raw_r, s_last_r;
  bst_pkg::point_t            s_pt_r;
  logic signed [34:0]         s_sx_r [2];
  logic signed [34:0]         s_sy_r [2];

  // Output register
  logic                       o_valid_r;
  logic signed [15:0]         o_x_r, o_y_r;
  logic                       o_last_r;
  logic signed [35:0]         accx, accy;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Pipeline advances unless a held result is stalled
  assign en = !o_valid_r || !out_stall;

  // Sequence the current job
  always_comb begin
    st_nxt    = st_r;
    job_nxt   = job_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    q_pop     = 1'b0;
    iss_valid = 1'b0;
    iss_raw   = 1'b1;
    iss_last  = 1'b0;
    iss_pt    = job_r.pts[0];
    unique case (st_r)
      B_IDLE: begin
        if (q_head.nonempty) begin
          q_pop   = 1'b1;
          job_nxt = q_head.head;
          idx_nxt = q_head.head.first_idx;
          j_nxt   = J_ONE;
          if (!q_head.head.curve) begin
            st_nxt = B_RAW;
          end else if (q_head.head.lead) begin
            st_nxt = B_LEAD;
          end else begin
            st_nxt = B_CURVE;
          end
        end
      end
      B_RAW: begin
        iss_valid = 1'b1;
        iss_pt    = job_r.pts[idx_r];
        iss_last  = (idx_r == job_r.last_idx) && job_r.strip_end;
        if (en) begin
          if (idx_r == job_r.last_idx) begin
            st_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      B_LEAD: begin
        iss_valid = 1'b1;
        if (en) begin
          st_nxt = B_CURVE;
        end
      end
      B_CURVE: begin
        iss_valid = 1'b1;
        iss_raw   = 1'b0;
        iss_last  = (j_r == J_LAST) && job_r.strip_end;
        if (en) begin
          if (j_r == J_LAST) begin
            st_nxt = B_IDLE;
          end else begin
            j_nxt = j_r + J_ONE;
          end
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    idx_r <= idx_nxt;
    j_r   <= j_nxt;
  end

  // Pipeline valid and flag bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (en) begin
      i_valid_r <= iss_valid;
      m_valid_r <= i_valid_r;
      s_valid_r <= m_valid_r;
      o_valid_r <= s_valid_r;
    end
  end

  // Final add with half-up rounding bias
  assign accx = 36'(s_sx_r[0]) + 36'(s_sx_r[1]) + 36'sd32768;
  assign accy = 36'(s_sy_r[0]) + 36'(s_sy_r[1]) + 36'sd32768;

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage I: fetch weights, copy control points
      i_raw_r    <= iss_raw;
      i_last_r   <= iss_last;
      i_w_r      <= bst_pkg::W_TAB[j_r];
      i_pts_r[0] <= iss_pt;
      i_pts_r[1] <= job_r.pts[1];
      i_pts_r[2] <= job_r.pts[2];
      i_pts_r[3] <= job_r.pts[3];

      // Stage M: weight times coordinate
      m_raw_r  <= i_raw_r;
      m_last_r <= i_last_r;
      m_pt_r   <= i_pts_r[0];
      for (int k = 0; k < 4; k++) begin
        m_px_r[k] <= 34'($signed({1'b0, i_w_r[k]})) * 34'($signed(i_pts_r[k][31:16]));
        m_py_r[k] <= 34'($signed({1'b0, i_w_r[k]})) * 34'($signed(i_pts_r[k][15:0]));
      end

      // Stage S: pair sums
      s_raw_r   <= m_raw_r;
      s_last_r  <= m_last_r;
      s_pt_r    <= m_pt_r;
      s_sx_r[0] <= 35'(m_px_r[0]) + 35'(m_px_r[1]);
      s_sx_r[1] <= 35'(m_px_r[2]) + 35'(m_px_r[3]);
      s_sy_r[0] <= 35'(m_py_r[0]) + 35'(m_py_r[1]);
      s_sy_r[1] <= 35'(m_py_r[2]) + 35'(m_py_r[3]);

      // Output: round, saturate or pass raw point
      o_last_r <= s_last_r;
      if (s_raw_r) begin
        o_x_r <= s_pt_r[31:16];
        o_y_r <= s_pt_r[15:0];
      end else begin
        o_x_r <= sat16(accx[35:16]);
        o_y_r <= sat16(accy[35:16]);
      end
    end
  end

  assign out_valid      = o_valid_r;
  assign out_x          = o_x_r;
  assign out_y          = o_y_r;
  assign out_strip_last = o_last_r;

endmodule

FILE: rtl/bezier_stroke_tessellator_core.sv
// ----------------------------------------------------------------------------
// bezier_stroke_tessellator_core
// Turns stroke points into line-strip vertices, smoothing every three points
// into a cubic Bezier group sampled at 20 steps.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall carries one point (in_x, in_y, Q12.4)
//    and in_stroke_end on the stroke's last point.
//  - Output channel out_valid/out_stall carries one vertex per request;
//    out_strip_last marks the final vertex of a stroke.
//  - cfg_valid/cfg_ready writes smooth_enable (1: Bezier, 0: pass through).
//    cfg_ready is always high; write only while the block is idle.
//  - Throughput: the back end issues one vertex per cycle while out_stall is
//    low, and passes through its idle state to load each job before its
//    vertices; raw jobs and cubic groups are handled the same way.
//  - The front end accepts points into a two-entry job queue; in_stall rises
//    while the queue is full.
//  - An out_stall while a vertex is offered freezes the whole vertex pipeline; the held vertex stays.
//  - Reset clears stroke state, empties the queue and pipeline, and sets
//    smooth_enable to 1.
// ----------------------------------------------------------------------------
module bezier_stroke_tessellator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic               in_stroke_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic               out_strip_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_smooth_enable
);

  bst_pkg::qpush_t q_push;
  bst_pkg::qhead_t q_head;
  logic            q_full;
  logic            q_pop;

  // Point intake and stroke tracking
  bst_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_x              (in_x),
    .in_y              (in_y),
    .in_stroke_end     (in_stroke_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_smooth_enable (cfg_smooth_enable),
    .q_full            (q_full),
    .q_push            (q_push)
  );

  // Job queue
  bst_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  // Vertex generation
  bst_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_strip_last (out_strip_last)
  );

endmodule

FILE: rtl/bst_checker.sv
// ----------------------------------------------------------------------------
// bst_checker
// Port-level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module bst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic               out_strip_last
);

  // Stalled vertex stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // Stalled vertex keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_strip_last))
    else $error("output payload changed while stalled");

  // Reset empties the vertex pipeline
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("vertex offered right after reset");

  // Reset leaves the job queue not full
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind bezier_stroke_tessellator_core bst_checker u_bst_checker (.*);
